>>> rtl/core/bhist_pkg.sv
// Shared types and constants for the byte histogram with sorted readout.
// Used by bhist_table, bhist_ctrl, the top level and the port checker.
// No dependencies.
package bhist_pkg;

	// Default sizing, handed down through the top level parameters
	localparam int unsigned SYMBOLS_DEF     = 256;
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	// Fixed field widths on the stream ports
	localparam int unsigned CMD_W = 2;
	localparam int unsigned SYM_W = 8;
	localparam int unsigned OCC_W = 32;
	localparam int unsigned OUT_DATA_W = SYM_W + OCC_W;

	// Command codes carried in the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_COUNT = 2'd0,
		CMD_FETCH = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT_WR,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Control strobes from the sequencer to the count memory
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} tbl_ctl_t;

endpackage

>>> rtl/core/byte_histogram_sorted_readout_unit.sv
// Top level of the byte histogram with sorted readout.
// Instantiates bhist_ctrl and bhist_table; depends on bhist_pkg.
//
// Counts bytes into one saturating counter per symbol and returns, one per
// fetch command, the symbols seen so far in descending order of count
// (equal counts: lower symbol first), each reported once until a clear.
// A fetch scans the whole count memory through its single read port, one entry
// per cycle. Reads of the memory are registered, so a count does a read then a
// write-back, and the sequencer takes no new item until that write has landed. A
// finished result waits in an output register while the next command is taken.
// Counts above 32 bits are reported as all ones. Reset and the clear command
// empty the table at once; no clearing pass is needed.
module byte_histogram_sorted_readout_unit
	import bhist_pkg::*;
#(
	parameter int unsigned SYMBOLS     = SYMBOLS_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] byte_value
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] symbol, [39:8] occurrences
	output logic [0:0]            m_tuser,   // [0] entry_valid
	output logic                  m_tlast    // final_entry
);

	localparam int unsigned AW = $clog2(SYMBOLS);

	tbl_ctl_t               ctl;
	logic [AW-1:0]          rd_addr, wr_addr;
	logic                   wr_mark, rd_mark;
	logic [COUNT_WIDTH-1:0] wr_count, rd_count;
	logic [SYM_W-1:0]       symbol;
	logic [OCC_W-1:0]       occ;
	logic                   entry_valid;

	bhist_ctrl #(
		.SYMBOLS     (SYMBOLS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_cmd         (s_tuser),
		.s_byte        (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_symbol      (symbol),
		.m_occ         (occ),
		.m_entry_valid (entry_valid),
		.m_final       (m_tlast),
		.ctl           (ctl),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.wr_mark       (wr_mark),
		.wr_count      (wr_count),
		.rd_mark       (rd_mark),
		.rd_count      (rd_count)
	);

	bhist_table #(
		.SYMBOLS     (SYMBOLS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_mark  (wr_mark),
		.wr_count (wr_count),
		.rd_mark  (rd_mark),
		.rd_count (rd_count)
	);

	// Pack the result fields, lowest first
	assign m_tdata = {occ, symbol};
	assign m_tuser = entry_valid;

endmodule

>>> rtl/core/bhist_table.sv
// Count memory: one word per symbol holding {reported mark, count}.
// Per-entry live bits give the all-zero reset and the immediate clear.
// Depends on bhist_pkg.
module bhist_table
	import bhist_pkg::*;
#(
	parameter int unsigned SYMBOLS     = SYMBOLS_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
	localparam int unsigned AW = $clog2(SYMBOLS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbl_ctl_t               ctl,
	input  logic [AW-1:0]          rd_addr,
	input  logic [AW-1:0]          wr_addr,
	input  logic                   wr_mark,
	input  logic [COUNT_WIDTH-1:0] wr_count,
	output logic                   rd_mark,
	output logic [COUNT_WIDTH-1:0] rd_count
);

	logic [COUNT_WIDTH:0]   mem [SYMBOLS];
	logic [SYMBOLS-1:0]     live_q;
	logic [COUNT_WIDTH:0]   rd_word_q;
	logic                   rd_live_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= {wr_mark, wr_count};
		end
		if (ctl.rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Track which entries hold data written since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			rd_live_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				live_q <= '0;
			end else if (ctl.wr_en) begin
				live_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_live_q <= live_q[rd_addr];
			end
		end
	end

	// An entry not written since clear reads as zero and unreported
	assign rd_mark  = rd_live_q & rd_word_q[COUNT_WIDTH];
	assign rd_count = rd_live_q ? rd_word_q[COUNT_WIDTH-1:0] : '0;

endmodule

>>> rtl/core/bhist_ctrl.sv
// Sequencer: counts by read-modify-write, fetches by scanning the count
// memory for the best unreported entry, and holds the result register.
// Depends on bhist_pkg; drives bhist_table.
module bhist_ctrl
	import bhist_pkg::*;
#(
	parameter int unsigned SYMBOLS     = SYMBOLS_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
	localparam int unsigned AW = $clog2(SYMBOLS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [CMD_W-1:0]       s_cmd,
	input  logic [SYM_W-1:0]       s_byte,
	// Result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [SYM_W-1:0]       m_symbol,
	output logic [OCC_W-1:0]       m_occ,
	output logic                   m_entry_valid,
	output logic                   m_final,
	// Count memory
	output tbl_ctl_t               ctl,
	output logic [AW-1:0]          rd_addr,
	output logic [AW-1:0]          wr_addr,
	output logic                   wr_mark,
	output logic [COUNT_WIDTH-1:0] wr_count,
	input  logic                   rd_mark,
	input  logic [COUNT_WIDTH-1:0] rd_count
);

	state_t                 state_q, state_d;
	logic [AW-1:0]          cnt_addr_q;
	logic [AW:0]            scan_q;
	logic                   eval_s1;
	logic [AW-1:0]          addr_s1;
	logic                   found_q, multi_q;
	logic [AW-1:0]          best_addr_q;
	logic [COUNT_WIDTH-1:0] best_cnt_q;
	logic                   out_vld_q;
	logic [SYM_W-1:0]       out_sym_q;
	logic [OCC_W-1:0]       out_occ_q;
	logic                   out_ent_q, out_fin_q;
	logic                   in_acc, in_range, scan_end, out_free, load_out;
	logic                   cand, better, scan_rd;
	logic [OCC_W-1:0]       best_occ;

	assign in_acc   = s_tvalid & s_tready;
	assign in_range = {1'b0, s_byte} < (SYM_W+1)'(SYMBOLS);
	assign scan_end = scan_q == (AW+1)'(SYMBOLS);
	assign out_free = ~out_vld_q | m_tready;
	assign scan_rd  = (state_q == ST_SCAN) & ~scan_end;

	// Clamp the count to the 32-bit result field
	if (COUNT_WIDTH > OCC_W) begin : g_sat
		assign best_occ = (|best_cnt_q[COUNT_WIDTH-1:OCC_W]) ? '1 : best_cnt_q[OCC_W-1:0];
	end else begin : g_ext
		assign best_occ = OCC_W'(best_cnt_q);
	end

	// Next state and memory strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ctl       = '0;
		rd_addr   = s_byte[AW-1:0];
		wr_addr   = cnt_addr_q;
		wr_mark   = rd_mark;
		wr_count  = (&rd_count) ? rd_count : rd_count + 1'b1;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					case (s_cmd)
						CMD_COUNT: begin
							if (in_range) begin
								ctl.rd_en = 1'b1;
								state_d   = ST_COUNT_WR;
							end
						end
						CMD_FETCH: state_d = ST_SCAN;
						CMD_CLEAR: ctl.clr = 1'b1;
						default: ;
					endcase
				end
			end
			ST_COUNT_WR: begin
				ctl.wr_en = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				rd_addr   = scan_q[AW-1:0];
				ctl.rd_en = scan_rd;
				if (scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				wr_addr  = best_addr_q;
				wr_mark  = 1'b1;
				wr_count = best_cnt_q;
				if (out_free) begin
					load_out  = 1'b1;
					ctl.wr_en = found_q;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Rank the entry returned by the memory against the best so far
	assign cand   = eval_s1 & ~rd_mark & (|rd_count);
	assign better = ~found_q | (rd_count > best_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			eval_s1   <= 1'b0;
			found_q   <= 1'b0;
			multi_q   <= 1'b0;
			out_vld_q <= 1'b0;
			scan_q    <= '0;
		end else begin
			state_q <= state_d;
			eval_s1 <= scan_rd;
			// Restart the scan on each fetch
			if (state_q == ST_IDLE) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				multi_q <= 1'b0;
			end else begin
				if (scan_rd) begin
					scan_q <= scan_q + 1'b1;
				end
				if (cand) begin
					found_q <= 1'b1;
					multi_q <= multi_q | found_q;
				end
			end
			// Drop the result once taken, load a new one when free
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnt_addr_q <= s_byte[AW-1:0];
		end
		if (scan_rd) begin
			addr_s1 <= scan_q[AW-1:0];
		end
		if (cand && better) begin
			best_addr_q <= addr_s1;
			best_cnt_q  <= rd_count;
		end
		if (load_out) begin
			out_sym_q <= found_q ? SYM_W'(best_addr_q) : '0;
			out_occ_q <= found_q ? best_occ : '0;
			out_ent_q <= found_q;
			out_fin_q <= found_q & ~multi_q;
		end
	end

	assign m_tvalid      = out_vld_q;
	assign m_symbol      = out_sym_q;
	assign m_occ         = out_occ_q;
	assign m_entry_valid = out_ent_q;
	assign m_final       = out_fin_q;

endmodule

>>> rtl/core/bhist_checker.sv
// Port-level checks on the byte histogram result stream, bound to the top.
// Depends on bhist_pkg.
module bhist_checker
	import bhist_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]            m_tuser,
	input logic                  m_tlast
);

	// Hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// An exhausted-list result carries only zeros
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tlast)
		else $error("exhausted result not all zero");

	// A reported entry was seen at least once
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[OUT_DATA_W-1:SYM_W] != '0)
		else $error("reported entry with zero count");

	// Raise the final flag only on a result that carries an entry
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("final flag without an entry");

endmodule

bind byte_histogram_sorted_readout_unit bhist_checker u_bhist_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> test/byte_histogram_sorted_readout_unit_tb.sv
// Self-checking bench for byte_histogram_sorted_readout_unit: drives count,
// fetch, clear and unused commands and checks every sorted readout against
// a predictor of the histogram. Depends on bhist_pkg and the top level only.
`timescale 1ns / 100ps

// One readout as the block should return it
typedef struct packed {
	logic [bhist_pkg::SYM_W-1:0] symbol;
	logic [bhist_pkg::OCC_W-1:0] occurrences;
	logic                        entry_valid;
	logic                        final_entry;
} readout_t;

// Histogram predictor and the queue of readouts still owed by the block
class ReadoutScoreboard;
	logic [bhist_pkg::OCC_W-1:0] tally [bhist_pkg::SYMBOLS_DEF];
	bit                          fetched [bhist_pkg::SYMBOLS_DEF];
	readout_t                    owed_q[$];
	int                          errors;

	function new();
		wipe();
		errors = 0;
	endfunction

	function void wipe();
		foreach (tally[i]) begin
			tally[i]   = '0;
			fetched[i] = 1'b0;
		end
	endfunction

	// Highest unfetched nonzero count, lower symbol on a tie; SYMBOLS_DEF if none
	function int unsigned top_symbol();
		int unsigned top;
		top = bhist_pkg::SYMBOLS_DEF;
		for (int unsigned i = 0; i < bhist_pkg::SYMBOLS_DEF; i++) begin
			if (tally[i] == '0 || fetched[i])
				continue;
			if (top == bhist_pkg::SYMBOLS_DEF || tally[i] > tally[top])
				top = i;
		end
		return top;
	endfunction

	// Apply one accepted input transaction to the predicted state
	function void note_input(logic [bhist_pkg::CMD_W-1:0] cmd, logic [7:0] value);
		readout_t    r;
		int unsigned top;
		r = '0;
		case (cmd)
			bhist_pkg::CMD_COUNT: begin
				if (tally[value] != '1)
					tally[value] = tally[value] + 1'b1;
			end
			bhist_pkg::CMD_CLEAR: wipe();
			bhist_pkg::CMD_FETCH: begin
				top = top_symbol();
				if (top != bhist_pkg::SYMBOLS_DEF) begin
					fetched[top]  = 1'b1;
					r.symbol      = top[bhist_pkg::SYM_W-1:0];
					r.occurrences = tally[top];
					r.entry_valid = 1'b1;
					r.final_entry = (top_symbol() == bhist_pkg::SYMBOLS_DEF);
				end
				owed_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function void report_field(string name, longint unsigned expv, longint unsigned act);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
	endfunction

	// Compare one accepted output transaction with the oldest owed readout
	function void check_result(logic [bhist_pkg::OUT_DATA_W-1:0] data, logic valid, logic last);
		readout_t got;
		readout_t want;
		got = {data[7:0], data[bhist_pkg::OUT_DATA_W-1:8], valid, last};
		if (owed_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected readout, expected none, actual symbol %0d count %0d",
				$time, got.symbol, got.occurrences);
			return;
		end
		want = owed_q.pop_front();
		if (got.symbol !== want.symbol)
			report_field("symbol", want.symbol, got.symbol);
		if (got.occurrences !== want.occurrences)
			report_field("occurrences", want.occurrences, got.occurrences);
		if (got.entry_valid !== want.entry_valid)
			report_field("entry_valid", want.entry_valid, got.entry_valid);
		if (got.final_entry !== want.final_entry)
			report_field("final_entry", want.final_entry, got.final_entry);
	endfunction

	function int owed();
		return owed_q.size();
	endfunction
endclass

module byte_histogram_sorted_readout_unit_tb;
	import bhist_pkg::*;

	localparam int unsigned RUN_ITEMS   = 1550;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned HOLD_OFF    = 800;
	localparam int unsigned DRAIN       = SYMBOLS_DEF + 20;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       value;
	} command_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = '0;   // [7:0] byte_value
	logic [CMD_W-1:0]      s_tuser  = '0;   // [1:0] command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [7:0] symbol, [39:8] occurrences
	logic [0:0]            m_tuser;         // [0] entry_valid
	logic                  m_tlast;         // final_entry

	command_t         cmd_q[$];
	ReadoutScoreboard board;
	int unsigned      taken_in  = 0;
	bit               cmds_done = 1'b0;
	int unsigned      quiet     = 0;

	always #5 clk = ~clk;

	byte_histogram_sorted_readout_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Idle odds by phase: sender 31 / receiver 57, then swapped, then none
	function automatic bit idle_now(bit sender_side);
		int unsigned phase;
		int unsigned pct;
		phase = taken_in * 3 / cmd_q.size();
		if (phase >= 2)
			return 1'b0;
		pct = ((phase == 0) == sender_side) ? 31 : 57;
		return $urandom_range(99) < pct;
	endfunction

	function automatic void add(logic [CMD_W-1:0] cmd, logic [7:0] value);
		cmd_q.push_back('{cmd, value});
	endfunction

	// Edge cases: empty fetch, ties, counting after a fetch, unused code, clear
	task automatic build_directed();
		add(CMD_FETCH, 8'hA5);
		add(CMD_COUNT, 8'h00);
		add(CMD_COUNT, 8'hFF);
		add(CMD_COUNT, 8'hFF);
		add(CMD_COUNT, 8'h80);
		add(CMD_FETCH, 8'h5A);
		add(CMD_FETCH, 8'h00);
		add(CMD_COUNT, 8'h00);
		add(CMD_FETCH, 8'hFF);
		add(CMD_FETCH, 8'h00);
		add(CMD_UNUSED, 8'h7F);
		add(CMD_FETCH, 8'h00);
		add(CMD_COUNT, 8'h7F);
		add(CMD_CLEAR, 8'hFF);
		add(CMD_FETCH, 8'h00);
		add(CMD_COUNT, 8'hFF);
		add(CMD_COUNT, 8'h55);
		add(CMD_COUNT, 8'h55);
		add(CMD_FETCH, 8'h33);
		add(CMD_FETCH, 8'hCC);
		add(CMD_CLEAR, 8'h00);
	endtask

	// Rounds of counts over a small alphabet, a readout run, then mostly a clear
	task automatic build_random();
		int         k;
		int         n;
		int         fetches;
		int         roll;
		int         round;
		logic [7:0] pool [40];
		round = 0;
		while (cmd_q.size() < RUN_ITEMS) begin
			round++;
			if (round == 12) begin
				// Wide round: most of the alphabet, read out to exhaustion
				for (int i = 0; i < 300; i++)
					add(CMD_COUNT, 8'($urandom_range(255)));
				for (int i = 0; i < 260; i++)
					add(CMD_FETCH, 8'($urandom_range(255)));
				add(CMD_CLEAR, 8'($urandom_range(255)));
				continue;
			end
			k = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
			for (int i = 0; i < k; i++)
				pool[i] = 8'($urandom_range(255));
			n = $urandom_range(3 * k + 4, k);
			for (int i = 0; i < n; i++) begin
				roll = $urandom_range(99);
				if (roll < 4)
					add(CMD_UNUSED, 8'($urandom_range(255)));
				else if (roll < 7)
					add(CMD_FETCH, 8'($urandom_range(255)));
				else if (roll < 10)
					add(CMD_COUNT, 8'($urandom_range(255)));
				else
					add(CMD_COUNT, pool[$urandom_range(k - 1)]);
			end
			fetches = ($urandom_range(4) == 0) ? $urandom_range(k) : k + 1;
			for (int i = 0; i < fetches; i++) begin
				if ($urandom_range(99) < 12)
					add(CMD_COUNT, pool[$urandom_range(k - 1)]);
				add(CMD_FETCH, 8'($urandom_range(255)));
			end
			if ($urandom_range(99) < 80)
				add(CMD_CLEAR, 8'($urandom_range(255)));
		end
	endtask

	// Offer each command, hold it until the transaction completes
	task automatic drive_commands();
		for (int unsigned idx = 0; idx < cmd_q.size(); idx++) begin
			while (idle_now(1'b1)) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser  <= cmd_q[idx].cmd;
			s_tdata  <= cmd_q[idx].value;
			do @(posedge clk); while (!(s_tvalid && s_tready));
			board.note_input(s_tuser, s_tdata);
			taken_in++;
			@(negedge clk);
		end
		s_tvalid  <= 1'b0;
		cmds_done = 1'b1;
	endtask

	// Accept readouts with random back-pressure and one long hold-off
	task automatic take_readouts();
		int unsigned seen;
		bit          held;
		seen = 0;
		held = 1'b0;
		forever begin
			if (!held && seen == 20) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end else begin
				m_tready <= !idle_now(1'b0);
				@(posedge clk);
				if (m_tvalid && m_tready) begin
					board.check_result(m_tdata, m_tuser[0], m_tlast);
					seen++;
				end
				@(negedge clk);
			end
		end
	endtask

	// Abort when no transaction moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		board = new();
		build_directed();
		build_random();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			drive_commands();
			take_readouts();
		join_none
		wait (cmds_done);
		while (board.owed() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (board.errors == 0 && board.owed() == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (board.owed() != 0)
				$display("%0t: %0d readouts never arrived", $time, board.owed());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
